[sv/lppt_pkg.sv]
// Package for the looping ping-pong progress timer.
// Holds field widths, action and play-mode codes, register indexes and helpers.
// No dependencies; every module of the block imports it.
package lppt_pkg;

  // Field widths.
  localparam int ValW    = 16;
  localparam int ActW    = 3;
  localparam int ModeW   = 3;
  localparam int CfgIdxW = 2;
  localparam int InDataW = 16;
  localparam int OutDataW = 40;

  // Width of the shared remainder unit: covers twice the largest duration.
  localparam int DivW = ValW + 1;

  // Signed width of a tick sum: count plus or minus amount.
  localparam int SumW = ValW + 2;

  // Register values after reset.
  localparam logic [ValW-1:0]  DurationReset = ValW'(1000);
  localparam logic [ModeW-1:0] ModeReset     = ModeW'(0);
  localparam logic [ValW-1:0]  StepReset     = ValW'(1);

  // Action codes.
  localparam logic [ActW-1:0] ACT_TICK  = 3'd0;
  localparam logic [ActW-1:0] ACT_START = 3'd1;
  localparam logic [ActW-1:0] ACT_STOP  = 3'd2;
  localparam logic [ActW-1:0] ACT_RESET = 3'd3;
  localparam logic [ActW-1:0] ACT_SET   = 3'd4;

  // Play modes.
  localparam logic [ModeW-1:0] MODE_FWD       = 3'd0;
  localparam logic [ModeW-1:0] MODE_LOOP      = 3'd1;
  localparam logic [ModeW-1:0] MODE_PINGPONG  = 3'd2;
  localparam logic [ModeW-1:0] MODE_BACK      = 3'd3;
  localparam logic [ModeW-1:0] MODE_BACK_LOOP = 3'd4;
  localparam logic [ModeW-1:0] MODE_BACK_PP   = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_DURATION  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PLAY_MODE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STEP_SIZE = 2'd2;

  // True for the three backward modes.
  function automatic logic mode_backward(input logic [ModeW-1:0] m);
    return (m == MODE_BACK) || (m == MODE_BACK_LOOP) || (m == MODE_BACK_PP);
  endfunction

  // Clamp a signed tick sum into the range zero to duration.
  function automatic logic [ValW-1:0] clamp_value(input logic signed [SumW-1:0] v,
                                                  input logic [ValW-1:0] d);
    logic [ValW-1:0] r;
    if (v[SumW-1]) begin
      r = '0;
    end else if (v[SumW-2:0] > {1'b0, d}) begin
      r = d;
    end else begin
      r = v[ValW-1:0];
    end
    return r;
  endfunction

endpackage

[sv/lppt_rem.sv]
// Iterative remainder unit, one restoring step per cycle.
// Shared by the tick modulo, the ping-pong fold and the quantizer.
// Depends on lppt_pkg.
module lppt_rem
  import lppt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DivW-1:0] dividend,
  input  logic [DivW-1:0] divisor,
  output logic            done,
  output logic [DivW-1:0] remainder
);

  localparam int CntW = $clog2(DivW);

  logic            busy;
  logic [CntW-1:0] step_cnt;
  logic [DivW-1:0] dvd;
  logic [DivW-1:0] dvs;
  logic [DivW:0]   trial;
  logic [DivW:0]   diff;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {remainder, dvd[DivW-1]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      step_cnt  <= '0;
      remainder <= '0;
      dvd       <= '0;
      dvs       <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        step_cnt  <= '0;
        remainder <= '0;
        dvd       <= dividend;
        dvs       <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          remainder <= diff[DivW-1:0];
        end else begin
          remainder <= trial[DivW-1:0];
        end
        dvd <= {dvd[DivW-2:0], 1'b0};
        if (step_cnt == CntW'(DivW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step_cnt <= step_cnt + 1'b1;
        end
      end
    end
  end

endmodule

[sv/looping_pingpong_progress_timer.sv]
// Top level of the progress timer: sequencer, timer state and registers.
// Depends on lppt_pkg and the shared remainder unit lppt_rem.
//
// Channel   Direction  Signals                             Contents
// s_axis    in         s_tvalid/s_tready/s_tdata/s_tuser   request: action and amount
// m_axis    out        m_tvalid/m_tready/m_tdata           value, quantized value, flags
// cfg       in         cfg_we/cfg_index/cfg_data           duration, play mode, step size
//
// A request is taken in S_IDLE, applied in S_EXEC, and quantized in S_QSTART and S_QUANT;
// S_OUT loads the output register before the next request is taken. A running tick that
// wraps or folds also uses S_WRAP: every looping tick, a backward-looping tick below zero
// and a ping-pong tick out of range. A remainder use is a load and 17 restoring steps.
// Reset is synchronous and returns the timer and registers to their reset values.
// A result waits in the output register while the next request is taken; the sequencer
// holds its own result until the output register is free.
module looping_pingpong_progress_timer
  import lppt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Input request.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // [15:0] amount
  input  logic [ActW-1:0]     s_tuser,   // [2:0] action
  // Result.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // [15:0] current_value, [31:16] quantized_value,
                                         // [32] running, [33] reached_end, rest zero
  // Configuration writes.
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [ValW-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WRAP,
    S_QSTART,
    S_QUANT,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [ValW-1:0]  duration;
  logic [ModeW-1:0] play_mode;
  logic [ValW-1:0]  step_size;

  // Timer state.
  logic [ValW-1:0] count_value;
  logic            going_down;
  logic            is_running;

  // Request and working registers.
  logic [ActW-1:0] act;
  logic [ValW-1:0] amt;
  logic            ended;
  logic            flip_neg;
  logic [ValW-1:0] quant;

  // Remainder unit interface.
  logic            div_start;
  logic [DivW-1:0] div_dividend;
  logic [DivW-1:0] div_divisor;
  logic            div_done;
  logic [DivW-1:0] div_rem;

  // Output register.
  logic [ValW-1:0] out_cur;
  logic [ValW-1:0] out_quant;
  logic            out_run;
  logic            out_end;

  // Tick arithmetic on the current state.
  logic signed [SumW-1:0] v_sum;
  logic signed [SumW-1:0] v_neg;
  logic [DivW-1:0]        v_mag;
  logic [DivW-1:0]        dur_ext;
  logic [DivW-1:0]        dur_twice;
  logic [DivW-1:0]        fold_w;
  logic [DivW-1:0]        fold_low;
  logic [ValW-1:0]        rewind_val;
  logic [ValW-1:0]        set_val;

  always_comb begin
    if (going_down) begin
      v_sum = $signed({2'b00, count_value}) - $signed({2'b00, amt});
    end else begin
      v_sum = $signed({2'b00, count_value}) + $signed({2'b00, amt});
    end
    v_neg      = -v_sum;
    v_mag      = v_sum[SumW-1] ? v_neg[DivW-1:0] : v_sum[DivW-1:0];
    dur_ext    = {1'b0, duration};
    dur_twice  = {duration, 1'b0};
    fold_w     = div_rem + 1'b1;
    fold_low   = dur_twice - fold_w;
    rewind_val = mode_backward(play_mode) ? duration : '0;
    set_val    = (amt > duration) ? duration : amt;
  end

  lppt_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{(OutDataW - 2*ValW - 2){1'b0}}, out_end, out_run, out_quant, out_cur};

  // Sequencer, timer state, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      duration     <= DurationReset;
      play_mode    <= ModeReset;
      step_size    <= StepReset;
      count_value  <= '0;
      going_down   <= 1'b0;
      is_running   <= 1'b0;
      ended        <= 1'b0;
      flip_neg     <= 1'b0;
      div_start    <= 1'b0;
      m_tvalid     <= 1'b0;
      act          <= '0;
      amt          <= '0;
      quant        <= '0;
      div_dividend <= '0;
      div_divisor  <= '0;
      out_cur      <= '0;
      out_quant    <= '0;
      out_run      <= 1'b0;
      out_end      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      // Drain the output register; in S_OUT a new result reloads it instead.
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        // Take a request.
        S_IDLE: begin
          if (s_tvalid) begin
            act   <= s_tuser;
            amt   <= s_tdata;
            ended <= 1'b0;
            state <= S_EXEC;
          end
        end

        // Apply the action; wraps and folds go to the remainder unit.
        S_EXEC: begin
          state <= S_QSTART;
          case (act)
            ACT_TICK: begin
              if (is_running) begin
                case (play_mode)
                  MODE_FWD: begin
                    if (!v_sum[SumW-1] && (v_sum[DivW-1:0] >= dur_ext)) begin
                      is_running <= 1'b0;
                      ended      <= 1'b1;
                    end
                    count_value <= clamp_value(v_sum, duration);
                  end
                  MODE_BACK: begin
                    if (v_sum[SumW-1] || (v_sum == '0)) begin
                      is_running <= 1'b0;
                      ended      <= 1'b1;
                    end
                    count_value <= clamp_value(v_sum, duration);
                  end
                  MODE_LOOP: begin
                    if (v_sum[SumW-1]) begin
                      count_value <= '0;
                    end else begin
                      div_dividend <= v_mag;
                      div_divisor  <= dur_ext;
                      div_start    <= 1'b1;
                      state        <= S_WRAP;
                    end
                  end
                  MODE_BACK_LOOP: begin
                    if (v_sum[SumW-1]) begin
                      div_dividend <= v_mag;
                      div_divisor  <= dur_ext;
                      div_start    <= 1'b1;
                      state        <= S_WRAP;
                    end else begin
                      count_value <= clamp_value(v_sum, duration);
                    end
                  end
                  MODE_PINGPONG, MODE_BACK_PP: begin
                    // A negative sum reflects at zero first.
                    flip_neg <= v_sum[SumW-1];
                    if (v_mag > dur_ext) begin
                      div_dividend <= v_mag - 1'b1;
                      div_divisor  <= dur_twice;
                      div_start    <= 1'b1;
                      state        <= S_WRAP;
                    end else begin
                      count_value <= v_mag[ValW-1:0];
                      going_down  <= going_down ^ v_sum[SumW-1];
                    end
                  end
                  default: begin
                    count_value <= clamp_value(v_sum, duration);
                  end
                endcase
              end
            end
            ACT_START: begin
              if (!is_running) begin
                is_running <= 1'b1;
                if ((count_value == '0) || (count_value == duration)) begin
                  count_value <= rewind_val;
                end
              end
            end
            ACT_STOP: begin
              is_running <= 1'b0;
            end
            ACT_RESET: begin
              count_value <= rewind_val;
            end
            ACT_SET: begin
              count_value <= set_val;
            end
            default: begin
            end
          endcase
        end

        // Finish a loop wrap or a ping-pong fold from the remainder.
        S_WRAP: begin
          if (div_done) begin
            state <= S_QSTART;
            case (play_mode)
              MODE_LOOP: begin
                count_value <= div_rem[ValW-1:0];
              end
              MODE_BACK_LOOP: begin
                count_value <= duration - div_rem[ValW-1:0];
              end
              default: begin
                // Fold over a period of twice the duration.
                if (fold_w > dur_ext) begin
                  count_value <= fold_low[ValW-1:0];
                  going_down  <= going_down ^ flip_neg ^ 1'b1;
                end else begin
                  count_value <= fold_w[ValW-1:0];
                  going_down  <= going_down ^ flip_neg;
                end
              end
            endcase
          end
        end

        // Quantize the stored value by the step size.
        S_QSTART: begin
          div_dividend <= {1'b0, count_value};
          div_divisor  <= {1'b0, step_size};
          div_start    <= 1'b1;
          state        <= S_QUANT;
        end

        S_QUANT: begin
          if (div_done) begin
            quant <= count_value - div_rem[ValW-1:0];
            state <= S_OUT;
          end
        end

        // Hand the result to the output register once it is free.
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            out_cur   <= count_value;
            out_quant <= quant;
            out_run   <= is_running;
            out_end   <= ended;
            m_tvalid  <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // Configuration writes must arrive only while the block is idle; the block does not enforce it.
      if (cfg_we) begin
        case (cfg_index)
          REG_DURATION: begin
            if (cfg_data != '0) begin
              duration <= cfg_data;
              if (count_value > cfg_data) begin
                count_value <= cfg_data;
              end
            end
          end
          REG_PLAY_MODE: begin
            if ((cfg_data[ModeW-1:0] <= MODE_BACK_PP) && (cfg_data[ModeW-1:0] != play_mode)) begin
              play_mode  <= cfg_data[ModeW-1:0];
              going_down <= mode_backward(cfg_data[ModeW-1:0]);
            end
          end
          REG_STEP_SIZE: begin
            if (cfg_data != '0) begin
              step_size <= cfg_data;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
